// ===== rtl/sladir_pkg.sv =====
// Package for segment length/angle/heading: constants, types and the arctangent table.
package sladir_pkg;

  localparam int COORD_BITS    = 12;
  localparam int SUBPIXEL_BITS = 4;
  localparam int ANGLE_STAGES  = 16;

  localparam int MAX_STAGES = 24;
  localparam int GUARD_BITS = 24;
  localparam int ANG_N      = (ANGLE_STAGES > MAX_STAGES) ? MAX_STAGES : ANGLE_STAGES;

  // square root: one result bit per cell
  localparam int ROOT_W = COORD_BITS + SUBPIXEL_BITS + 1;
  localparam int SQ_N   = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SUMSQ_W = 2 * DIFF_W + 1;

  localparam int NCELL  = (ROOT_W > ANG_N) ? ROOT_W : ANG_N;
  localparam int IDX_W  = $clog2(NCELL + 1);
  localparam int LAT    = NCELL + 2;

  // midpoint-to-end vector and rotator widths
  localparam int VEC_BITS = (COORD_BITS + SUBPIXEL_BITS > 16) ? COORD_BITS + SUBPIXEL_BITS : 16;
  localparam int VW       = VEC_BITS + 2;
  localparam int CW       = VEC_BITS + GUARD_BITS + 3;
  localparam int ZW       = 26;

  localparam int LEN_W   = 17;
  localparam int ANGLE_W = 15;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic signed [ZW-1:0] ANG_RIGHT = ZW'(11520);
  localparam logic signed [ZW-1:0] ANG_ROUND = ZW'(256);

  typedef enum logic [1:0] {
    HEAD_LEFT  = 2'd0,
    HEAD_RIGHT = 2'd1,
    HEAD_UP    = 2'd2,
    HEAD_DOWN  = 2'd3
  } heading_t;

  typedef enum logic [1:0] {
    ACTL_CORDIC = 2'd0,
    ACTL_ZERO   = 2'd1,
    ACTL_RIGHT  = 2'd2
  } actl_t;

  typedef struct packed {
    logic                    vld;
    logic [SQ_N-1:0]         n;
    logic [REM_W-1:0]        rem;
    logic [ROOT_W-1:0]       root;
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [ZW-1:0]    z;
    actl_t                   actl;
    logic                    neg;
    heading_t                head;
  } cell_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [ZW-1:0] atan_lut(input logic [IDX_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (5'(i))
      5'd0:  v = ZW'(2949120);
      5'd1:  v = ZW'(1740967);
      5'd2:  v = ZW'(919879);
      5'd3:  v = ZW'(466945);
      5'd4:  v = ZW'(234379);
      5'd5:  v = ZW'(117266);
      5'd6:  v = ZW'(58666);
      5'd7:  v = ZW'(29335);
      5'd8:  v = ZW'(14668);
      5'd9:  v = ZW'(7334);
      5'd10: v = ZW'(3667);
      5'd11: v = ZW'(1833);
      5'd12: v = ZW'(917);
      5'd13: v = ZW'(458);
      5'd14: v = ZW'(229);
      5'd15: v = ZW'(115);
      5'd16: v = ZW'(57);
      5'd17: v = ZW'(29);
      5'd18: v = ZW'(14);
      5'd19: v = ZW'(7);
      5'd20: v = ZW'(4);
      5'd21: v = ZW'(2);
      5'd22: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/sladir_front.sv =====
// Input stage: differences, squared length, folded angle vector and heading.
module sladir_front
  import sladir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [11:0] start_x,
  input  logic [11:0] end_x,
  input  logic [11:0] start_y,
  input  logic [11:0] end_y,
  input  logic [15:0] mid_x,
  input  logic [15:0] mid_y,
  output cell_t       q
);

  logic [COORD_BITS-1:0]      sx, ex, sy, ey;
  logic signed [DIFF_W-1:0]   dx, dy;
  logic signed [2*DIFF_W-1:0] sq_x, sq_y;
  logic [SUMSQ_W-1:0]         sumsq;
  logic signed [VW-1:0]       vx, vy, fx, fy, ay;
  cell_t                      q_nxt;

  always_comb begin
    sx = start_x[COORD_BITS-1:0];
    ex = end_x[COORD_BITS-1:0];
    sy = start_y[COORD_BITS-1:0];
    ey = end_y[COORD_BITS-1:0];
    dx = signed'(DIFF_W'(ex)) - signed'(DIFF_W'(sx));
    dy = signed'(DIFF_W'(ey)) - signed'(DIFF_W'(sy));
    // full-width squares
    sq_x  = dx * dx;
    sq_y  = dy * dy;
    sumsq = SUMSQ_W'(unsigned'(sq_x)) + SUMSQ_W'(unsigned'(sq_y));

    vx = signed'(VW'(ex) << SUBPIXEL_BITS) - signed'(VW'(mid_x));
    vy = signed'(VW'(ey) << SUBPIXEL_BITS) - signed'(VW'(mid_y));
    // fold backward vectors by 180 degrees
    fx = (vx < 0) ? -vx : vx;
    fy = (vx < 0) ? -vy : vy;
    ay = (fy < 0) ? -fy : fy;

    q_nxt.vld  = acc;
    q_nxt.n    = SQ_N'(sumsq) << (2 * SUBPIXEL_BITS);
    q_nxt.rem  = '0;
    q_nxt.root = '0;
    q_nxt.x    = signed'(CW'(fx)) <<< GUARD_BITS;
    q_nxt.y    = signed'(CW'(ay)) <<< GUARD_BITS;
    q_nxt.z    = '0;
    q_nxt.neg  = 1'b0;
    if (sx == ex) begin
      q_nxt.actl = ACTL_RIGHT;
    end else if (ay == '0) begin
      q_nxt.actl = ACTL_ZERO;
    end else if (fx == '0) begin
      q_nxt.actl = ACTL_RIGHT;
      q_nxt.neg  = (fy < 0);
    end else begin
      q_nxt.actl = ACTL_CORDIC;
      q_nxt.neg  = (fy < 0);
    end

    if (sx > ex)      q_nxt.head = HEAD_LEFT;
    else if (sx < ex) q_nxt.head = HEAD_RIGHT;
    else if (sy > ey) q_nxt.head = HEAD_UP;
    else              q_nxt.head = HEAD_DOWN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) q <= '0;
    else        q <= q_nxt;
  end

endmodule

// ===== rtl/sladir_cell.sv =====
// One chain cell: one square-root digit and one CORDIC rotation, each only while idx is within that chain.
module sladir_cell
  import sladir_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] idx,
  input  cell_t            d,
  output cell_t            q
);

  logic [1:0]           pair;
  logic [REM_W-1:0]     racc, trial;
  logic signed [CW-1:0] xs, ys;
  cell_t                q_nxt;

  always_comb begin
    q_nxt = d;
    pair  = d.n[SQ_N-1 -: 2];
    racc  = REM_W'({d.rem, pair});
    trial = REM_W'({d.root, 2'b01});
    xs    = d.x >>> idx;
    ys    = d.y >>> idx;

    if (idx < IDX_W'(ROOT_W)) begin
      q_nxt.n = d.n << 2;
      if (racc >= trial) begin
        q_nxt.rem  = racc - trial;
        q_nxt.root = ROOT_W'({d.root, 1'b1});
      end else begin
        q_nxt.rem  = racc;
        q_nxt.root = ROOT_W'({d.root, 1'b0});
      end
    end

    if (idx < IDX_W'(ANG_N)) begin
      if (d.y > 0) begin
        q_nxt.x = d.x + ys;
        q_nxt.y = d.y - xs;
        q_nxt.z = d.z + atan_lut(idx);
      end else begin
        q_nxt.x = d.x - ys;
        q_nxt.y = d.y + xs;
        q_nxt.z = d.z - atan_lut(idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) q <= '0;
    else        q <= q_nxt;
  end

endmodule

// ===== rtl/sladir_back.sv =====
// Output stage: length rounding, angle rounding, clamp and sign.
module sladir_back
  import sladir_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cell_t                     d,
  output logic                      out_valid,
  output logic [LEN_W-1:0]          out_seg_length,
  output logic signed [ANGLE_W-1:0] out_seg_angle,
  output logic [1:0]                out_seg_heading
);

  logic [ROOT_W:0]         len_rnd;
  logic [LEN_W-1:0]        len_nxt;
  logic signed [ZW-1:0]    qa, mag;
  logic signed [ANGLE_W-1:0] ang_nxt;

  always_comb begin
    len_rnd = (REM_W'(d.root) < d.rem) ? {1'b0, d.root} + 1'b1 : {1'b0, d.root};
    len_nxt = (len_rnd > (ROOT_W+1)'(LEN_MAX)) ? LEN_MAX : LEN_W'(len_rnd);

    qa = (d.z + ANG_ROUND) >>> 9;
    if (qa < 0)              qa = '0;
    else if (qa > ANG_RIGHT) qa = ANG_RIGHT;

    case (d.actl)
      ACTL_ZERO:  mag = '0;
      ACTL_RIGHT: mag = ANG_RIGHT;
      default:    mag = qa;
    endcase
    ang_nxt = d.neg ? -ANGLE_W'(mag) : ANGLE_W'(mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= d.vld;
  end

  always_ff @(posedge clk) begin
    out_seg_length  <= len_nxt;
    out_seg_angle   <= ang_nxt;
    out_seg_heading <= d.head;
  end

endmodule

// ===== rtl/segment_length_angle_direction_top.sv =====
// Top level: line segment length, angle and heading as a chain of cells.
//
// Usage: drive start high with one segment on the in_ ports; busy is
// always low, so a transaction is taken on every cycle that start is high.
// Each transaction produces exactly one result: out_valid pulses for one
// cycle with out_seg_length, out_seg_angle and out_seg_heading.
//
// The chain is one input stage, one registered cell per square-root bit /
// CORDIC rotation (whichever chain is longer sets NCELL), and one output stage.
// Throughput is one transaction per cycle; every cell hands its state to
// its neighbor each clock.
//
// Reset (synchronous, rst_n low) clears the valid bits of all stages, so
// transactions in flight are dropped and no result appears afterward for
// them. The receiver cannot stall: results are shown for exactly one cycle.
module segment_length_angle_direction_top
  import sladir_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [11:0]               in_start_x,
  input  logic [11:0]               in_end_x,
  input  logic [11:0]               in_start_y,
  input  logic [11:0]               in_end_y,
  input  logic [15:0]               in_mid_x,
  input  logic [15:0]               in_mid_y,
  output logic                      out_valid,
  output logic [LEN_W-1:0]          out_seg_length,
  output logic signed [ANGLE_W-1:0] out_seg_angle,
  output logic [1:0]                out_seg_heading
);

  cell_t chain [NCELL+1];

  // fully pipelined, never holds off a transaction
  assign busy = 1'b0;

  sladir_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (start & ~busy),
    .start_x (in_start_x),
    .end_x   (in_end_x),
    .start_y (in_start_y),
    .end_y   (in_end_y),
    .mid_x   (in_mid_x),
    .mid_y   (in_mid_y),
    .q       (chain[0])
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    sladir_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .idx   (IDX_W'(g)),
      .d     (chain[g]),
      .q     (chain[g+1])
    );
  end

  sladir_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .d               (chain[NCELL]),
    .out_valid       (out_valid),
    .out_seg_length  (out_seg_length),
    .out_seg_angle   (out_seg_angle),
    .out_seg_heading (out_seg_heading)
  );

  // a result only ever follows an earlier accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without matching transaction");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_seg_angle <= 15'sd11520) && (out_seg_angle >= -15'sd11520))
    else $error("angle outside +/-90 degrees");

  // up/down heading means a vertical segment, which is forced to 90 degrees
  a_vertical: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_seg_heading == HEAD_UP || out_seg_heading == HEAD_DOWN)
    |-> out_seg_angle == 15'sd11520)
    else $error("vertical segment not at 90 degrees");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the segment length, angle and heading pipeline.
module tb_top
  import sladir_pkg::*;
;

  typedef struct {
    logic [16:0] length;
    logic [14:0] angle;
    heading_t    heading;
  } seg_result_t;

  // Scoreboard: predicts the result of each segment and checks results in order.
  class segment_scoreboard;
    seg_result_t pending[$];
    int unsigned mismatches;
    int unsigned checked;

    // floor(v / 2^s); >>> on a signed longint is an arithmetic shift
    static function longint fshift(longint v, int s);
      return v >>> s;
    endfunction

    static function longint rounded_root(longint unsigned n);
      longint unsigned r, lo, hi, mid;
      lo = 0;
      hi = 1 << 20;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (mid * mid <= n) lo = mid;
        else hi = mid - 1;
      end
      r = lo;
      if (n - r * r > r) r++;
      return r;
    endfunction

    static function longint atan_step(int i);
      longint tab[24];
      tab = '{2949120, 1740967, 919879, 466945, 234379, 117266, 58666, 29335,
              14668, 7334, 3667, 1833, 917, 458, 229, 115,
              57, 29, 14, 7, 4, 2, 1, 0};
      return tab[i];
    endfunction

    // first-quadrant vector angle, 1/128 degree
    static function longint quadrant_angle(longint x, longint y);
      longint z, q, xs, ys;
      int stages;
      z = 0;
      if (y == 0) return 0;
      if (x == 0) return 11520;
      stages = (ANGLE_STAGES > 24) ? 24 : ANGLE_STAGES;
      x = x <<< GUARD_BITS;
      y = y <<< GUARD_BITS;
      for (int i = 0; i < stages; i++) begin
        xs = fshift(x, i);
        ys = fshift(y, i);
        if (y > 0) begin
          x += ys; y -= xs; z += atan_step(i);
        end else begin
          x -= ys; y += xs; z -= atan_step(i);
        end
      end
      q = fshift(z + 256, 9);
      if (q < 0) q = 0;
      if (q > 11520) q = 11520;
      return q;
    endfunction

    function void note_segment(logic [11:0] sx_i, logic [11:0] ex_i, logic [11:0] sy_i,
                               logic [11:0] ey_i, logic [15:0] mx_i, logic [15:0] my_i);
      seg_result_t r;
      longint sx, ex, sy, ey, dx, dy, len, ang, vx, vy;
      longint unsigned n;
      sx = sx_i; ex = ex_i; sy = sy_i; ey = ey_i;
      dx = ex - sx;
      dy = ey - sy;
      n = longint'(dx * dx + dy * dy) << (2 * SUBPIXEL_BITS);
      len = rounded_root(n);
      if (len > 131071) len = 131071;
      if (sx == ex) ang = 11520;
      else begin
        vx = (ex <<< SUBPIXEL_BITS) - longint'(mx_i);
        vy = (ey <<< SUBPIXEL_BITS) - longint'(my_i);
        if (vx < 0) begin
          vx = -vx; vy = -vy;
        end
        if (vy < 0) ang = -quadrant_angle(vx, -vy);
        else ang = quadrant_angle(vx, vy);
      end
      if (sx > ex) r.heading = HEAD_LEFT;
      else if (sx < ex) r.heading = HEAD_RIGHT;
      else if (sy > ey) r.heading = HEAD_UP;
      else r.heading = HEAD_DOWN;
      r.length = len[16:0];
      r.angle = ang[14:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [16:0] len, logic [14:0] ang, logic [1:0] head);
      seg_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result len=%0d ang=%0d", len, ang);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (len !== e.length || ang !== e.angle || head !== e.heading) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: exp len=%0d ang=%0d head=%0d, got len=%0d ang=%0d head=%0d",
                   checked, e.length, $signed(e.angle), e.heading,
                   len, $signed(ang), head);
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, out_valid;
  logic [11:0] in_start_x, in_end_x, in_start_y, in_end_y;
  logic [15:0] in_mid_x, in_mid_y;
  logic [16:0] out_seg_length;
  logic signed [14:0] out_seg_angle;
  logic [1:0] out_seg_heading;

  segment_scoreboard board;
  int unsigned idle_pct;     // sender idle chance per cycle, percent
  int unsigned quiet_cycles; // watchdog: cycles with neither a transaction nor a result
  int unsigned sent;
  localparam int WATCHDOG = 2000;

  segment_length_angle_direction_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_x(in_start_x), .in_end_x(in_end_x),
    .in_start_y(in_start_y), .in_end_y(in_end_y),
    .in_mid_x(in_mid_x), .in_mid_y(in_mid_y),
    .out_valid(out_valid), .out_seg_length(out_seg_length),
    .out_seg_angle(out_seg_angle), .out_seg_heading(out_seg_heading)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sample at the rising edge: input transactions go to the scoreboard as
  // predictions, results are checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      board.note_segment(in_start_x, in_end_x, in_start_y, in_end_y, in_mid_x, in_mid_y);
      sent++;
    end
    if (rst_n && out_valid)
      board.check_result(out_seg_length, out_seg_angle, out_seg_heading);
    if (rst_n && !(start && !busy) && !out_valid) quiet_cycles++;
    else quiet_cycles = 0;
    if (quiet_cycles >= WATCHDOG) begin
      $display("watchdog expired, %0d results outstanding", board.pending.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Present one segment at the falling edge, then hold it until taken.
  // start stays high across back-to-back transactions.
  task automatic send_segment(logic [11:0] sx, logic [11:0] ex, logic [11:0] sy,
                              logic [11:0] ey, logic [15:0] mx, logic [15:0] my);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_start_x <= sx; in_end_x <= ex; in_start_y <= sy; in_end_y <= ey;
    in_mid_x <= mx; in_mid_y <= my;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random segment; mode picks the shape to reach the special cases.
  task automatic send_random();
    logic [11:0] sx, ex, sy, ey;
    logic [15:0] mx, my;
    int unsigned mode;
    mode = $urandom_range(9);
    sx = 12'($urandom); ex = 12'($urandom); sy = 12'($urandom); ey = 12'($urandom);
    mx = 16'($urandom); my = 16'($urandom);
    case (mode)
      0: ex = sx;                               // vertical segment
      1: begin                                  // midpoint on the end point
        mx = {ex, 4'h0}; my = {ey, 4'h0};
      end
      2: begin                                  // vertical vector from midpoint
        if (ex == sx) ex = sx + 12'd1;
        mx = {ex, 4'h0};
      end
      3: my = {ey, 4'h0};                       // horizontal vector
      4: begin                                  // short segment, nearby midpoint
        ex = sx + 12'($urandom_range(8)) - 12'd4;
        ey = sy + 12'($urandom_range(8)) - 12'd4;
        mx = {ex, 4'h0} + 16'($urandom_range(64)) - 16'd32;
        my = {ey, 4'h0} + 16'($urandom_range(64)) - 16'd32;
      end
      5: begin                                  // true midpoint
        mx = 16'((({4'h0, sx} + ex) * 16) / 2); my = 16'((({4'h0, sy} + ey) * 16) / 2);
      end
      default: ;
    endcase
    send_segment(sx, ex, sy, ey, mx, my);
  endtask

  initial begin
    board = new();
    idle_pct = 8;
    sent = 0;
    quiet_cycles = 0;
    rst_n = 0; start = 0;
    in_start_x = 0; in_end_x = 0; in_start_y = 0; in_end_y = 0;
    in_mid_x = 0; in_mid_y = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: extremes, every heading and each special case.
    send_segment(12'd0, 12'd0, 12'd0, 12'd0, 16'd0, 16'd0);           // zero length, down
    send_segment(12'd0, 12'd4095, 12'd0, 12'd4095, 16'd0, 16'd0);     // longest diagonal
    send_segment(12'd4095, 12'd0, 12'd4095, 12'd0, 16'hFFFF, 16'hFFFF);
    send_segment(12'd100, 12'd100, 12'd200, 12'd50, 16'd1234, 16'd5678); // vertical, up
    send_segment(12'd100, 12'd100, 12'd50, 12'd200, 16'd0, 16'hFFFF);    // vertical, down
    send_segment(12'd10, 12'd20, 12'd5, 12'd5, 16'd320, 16'd80);      // midpoint on end
    send_segment(12'd10, 12'd20, 12'd5, 12'd9, 16'd320, 16'd80);      // vertical vector, +Y
    send_segment(12'd10, 12'd20, 12'd9, 12'd5, 16'd320, 16'd200);     // vertical vector, -Y
    send_segment(12'd30, 12'd20, 12'd5, 12'd5, 16'd400, 16'd80);      // backward, zero angle
    send_segment(12'd30, 12'd20, 12'd5, 12'd9, 16'd400, 16'd100);     // backward, tilted
    send_segment(12'd0, 12'd4095, 12'd4095, 12'd0, 16'hFFFF, 16'hFFFF);
    send_segment(12'd4095, 12'd0, 12'd0, 12'd4095, 16'd0, 16'd0);
    send_segment(12'hAAA, 12'h555, 12'h555, 12'hAAA, 16'hAAAA, 16'h5555);
    send_segment(12'h555, 12'hAAA, 12'hAAA, 12'h555, 16'h5555, 16'hAAAA);
    send_segment(12'd1, 12'd2, 12'd1, 12'd2, 16'd16, 16'd16);         // 45 degrees
    send_segment(12'd2, 12'd1, 12'd2, 12'd1, 16'd32, 16'd32);

    for (int i = 0; i < 1850; i++) begin
      if (i == 600) idle_pct = 54;
      else if (i == 1200) idle_pct = 0;
      send_random();
    end
    @(negedge clk);
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LAT + 5) @(posedge clk);
    $display("Ran %0d segments (%0d results checked): directed corners and random",
             sent, board.checked);
    $display("shapes incl. vertical, degenerate and backward vectors under sender gaps.");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("FAILURE");
    end
    $finish;
  end
endmodule
